// ----- design/wavhp_pkg.sv -----
// wavhp_pkg: types and constants shared by wavhp_parse and wav_header_parser_core.
// No dependencies.

package wavhp_pkg;

  // Chunk tags as they appear in the byte stream, first byte in the low byte
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // PCM format code in the fmt chunk
  localparam logic [15:0] FMT_PCM = 16'd1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_WAVE    = 3'd1,
    ST_NO_FMT     = 3'd2,
    ST_NOT_PCM    = 3'd3,
    ST_NO_DATA    = 3'd4,
    ST_ZERO_WIDTH = 3'd5
  } status_e;

  // Where the chunk walker is
  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_WAVE   = 2'd1,
    PH_CHAIN  = 2'd2,
    PH_BAD    = 2'd3
  } phase_e;

  // Top-level sequencer
  typedef enum logic [1:0] {
    CTL_PARSE  = 2'd0,
    CTL_FINISH = 2'd1,
    CTL_DIV    = 2'd2
  } ctl_state_e;

  // Everything the parser has gathered, handed to the result logic
  typedef struct packed {
    logic        wave_ok;
    logic        fmt_found;
    logic        data_found;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [31:0] data_length;
    logic [31:0] data_start;
  } parse_res_t;

endpackage

// ----- design/wavhp_parse.sv -----
// wavhp_parse: byte-wise RIFF chunk walker and fmt/data field capture.
// Depends on wavhp_pkg.

module wavhp_parse #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  clear_i,
  input  logic [7:0]            data_byte_i,
  output wavhp_pkg::parse_res_t res_o
);

  localparam int unsigned NW = 33;

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] next_q, next_d;
  logic [POSITION_BITS-1:0] riff_q, riff_d;
  logic [POSITION_BITS-1:0] dstart_q, dstart_d;
  wavhp_pkg::phase_e        phase_q, phase_d;
  logic [63:0]              shift_q, shift_d;
  logic [9:0][7:0]          cap_q, cap_d;
  logic                     fmt_found_q, fmt_found_d;
  logic                     fmt_on_q, fmt_on_d;
  logic [3:0]               fmt_rel_q, fmt_rel_d;
  logic                     data_found_q, data_found_d;
  logic [31:0]              dlen_q, dlen_d;
  logic                     stopped_q, stopped_d;

  logic                     parse_en;
  logic [63:0]              shift_new;
  logic [31:0]              name;
  logic [31:0]              len;
  logic [31:0]              pad;
  logic [NW-1:0]            nxt;
  logic                     nxt_over;
  logic                     hdr_hit;
  logic                     wave_hit;

  // Bytes at the saturated position take no part in parsing
  assign parse_en  = step_i && (pos_q != {POSITION_BITS{1'b1}});
  assign shift_new = {data_byte_i, shift_q[63:8]};
  assign name      = shift_new[31:0];
  assign len       = shift_new[63:32];

  // Shared chain adder: next header = this header + 8 + even-padded length
  assign pad      = (len + 32'd1) & ~32'd1;
  assign nxt      = NW'(next_q) + NW'(8) + NW'(pad);
  assign nxt_over = |nxt[NW-1:POSITION_BITS];

  assign hdr_hit  = ((phase_q == wavhp_pkg::PH_SEARCH) || (phase_q == wavhp_pkg::PH_CHAIN)) &&
                    !stopped_q &&
                    ({1'b0, pos_q} == ({1'b0, next_q} + (POSITION_BITS+1)'(7)));
  assign wave_hit = (phase_q == wavhp_pkg::PH_WAVE) &&
                    ({1'b0, pos_q} == ({1'b0, riff_q} + (POSITION_BITS+1)'(11)));

  // Next-state logic for the walker
  always_comb begin
    pos_d        = pos_q;
    next_d       = next_q;
    riff_d       = riff_q;
    dstart_d     = dstart_q;
    phase_d      = phase_q;
    shift_d      = shift_q;
    cap_d        = cap_q;
    fmt_found_d  = fmt_found_q;
    fmt_on_d     = fmt_on_q;
    fmt_rel_d    = fmt_rel_q;
    data_found_d = data_found_q;
    dlen_d       = dlen_q;
    stopped_d    = stopped_q;

    if (clear_i) begin
      pos_d        = '0;
      next_d       = '0;
      riff_d       = '0;
      dstart_d     = '0;
      phase_d      = wavhp_pkg::PH_SEARCH;
      shift_d      = '0;
      cap_d        = '0;
      fmt_found_d  = 1'b0;
      fmt_on_d     = 1'b0;
      fmt_rel_d    = '0;
      data_found_d = 1'b0;
      dlen_d       = '0;
      stopped_d    = 1'b0;
    end else if (parse_en) begin
      shift_d = shift_new;
      pos_d   = pos_q + POSITION_BITS'(1);

      // fmt body: offsets 0..7 and 14..15
      if (fmt_on_q) begin
        if (!fmt_rel_q[3]) begin
          cap_d[{1'b0, fmt_rel_q[2:0]}] = data_byte_i;
        end else if (fmt_rel_q[3:1] == 3'b111) begin
          cap_d[{3'b100, fmt_rel_q[0]}] = data_byte_i;
        end
        if (fmt_rel_q == 4'hF) begin
          fmt_on_d = 1'b0;
        end else begin
          fmt_rel_d = fmt_rel_q + 4'd1;
        end
      end

      // Chunk header complete
      if (hdr_hit) begin
        if (len[31]) begin
          stopped_d = 1'b1;
        end else if (phase_q == wavhp_pkg::PH_SEARCH && name == wavhp_pkg::TAG_RIFF) begin
          riff_d  = next_q;
          phase_d = wavhp_pkg::PH_WAVE;
        end else begin
          if (phase_q == wavhp_pkg::PH_CHAIN) begin
            if (name == wavhp_pkg::TAG_FMT && !fmt_found_q) begin
              fmt_found_d = 1'b1;
              fmt_on_d    = 1'b1;
              fmt_rel_d   = '0;
            end
            if (name == wavhp_pkg::TAG_DATA && !data_found_q) begin
              data_found_d = 1'b1;
              dlen_d       = len;
              dstart_d     = next_q + POSITION_BITS'(8);
            end
          end
          if (nxt_over) begin
            stopped_d = 1'b1;
          end else begin
            next_d = nxt[POSITION_BITS-1:0];
          end
        end
      end else if (wave_hit) begin
        // Form type at RIFF offset 8
        if (len == wavhp_pkg::TAG_WAVE) begin
          phase_d   = wavhp_pkg::PH_CHAIN;
          next_d    = riff_q + POSITION_BITS'(12);
          stopped_d = 1'b0;
        end else begin
          phase_d = wavhp_pkg::PH_BAD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      next_q       <= '0;
      riff_q       <= '0;
      dstart_q     <= '0;
      phase_q      <= wavhp_pkg::PH_SEARCH;
      shift_q      <= '0;
      cap_q        <= '0;
      fmt_found_q  <= 1'b0;
      fmt_on_q     <= 1'b0;
      fmt_rel_q    <= '0;
      data_found_q <= 1'b0;
      dlen_q       <= '0;
      stopped_q    <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      next_q       <= next_d;
      riff_q       <= riff_d;
      dstart_q     <= dstart_d;
      phase_q      <= phase_d;
      shift_q      <= shift_d;
      cap_q        <= cap_d;
      fmt_found_q  <= fmt_found_d;
      fmt_on_q     <= fmt_on_d;
      fmt_rel_q    <= fmt_rel_d;
      data_found_q <= data_found_d;
      dlen_q       <= dlen_d;
      stopped_q    <= stopped_d;
    end
  end

  // Gathered fields
  assign res_o.wave_ok         = (phase_q == wavhp_pkg::PH_CHAIN);
  assign res_o.fmt_found       = fmt_found_q;
  assign res_o.data_found      = data_found_q;
  assign res_o.format_tag      = {cap_q[1], cap_q[0]};
  assign res_o.channel_count   = {cap_q[3], cap_q[2]};
  assign res_o.sample_rate     = {cap_q[7], cap_q[6], cap_q[5], cap_q[4]};
  assign res_o.bits_per_sample = {cap_q[9], cap_q[8]};
  assign res_o.data_length     = dlen_q;
  assign res_o.data_start      = 32'(dstart_q);

endmodule

// ----- design/wavhp_div.sv -----
// wavhp_div: restoring divider, one quotient bit per cycle on a shared subtractor.
// Depends on nothing.

module wavhp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [12:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [31:0] quo_q;
  logic [12:0] rem_q;
  logic [12:0] dvs_q;
  logic        done_q;

  logic [13:0] trial;
  logic [13:0] diff;
  logic        fits;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_q, quo_q[31]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = !diff[13];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[30:0], fits};
      rem_q <= fits ? diff[12:0] : trial[12:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- design/wav_header_parser_core.sv -----
// wav_header_parser_core: WAV header parser top level, sequencer and result register.
// Depends on wavhp_pkg, wavhp_parse and wavhp_div.
//
//  channel | signals                                   | dir | transfer when
//  --------+-------------------------------------------+-----+------------------------
//  in      | in_valid_i, in_stall_o, data_byte_i,      | in  | in_valid_i && !in_stall_o
//          | last_i                                    |     |
//  out     | out_valid_o, out_stall_i, status_o,       | out | out_valid_o && !out_stall_i
//          | format_tag_o .. data_offset_o             |     |
//
// Input is stalled after the last byte of a file while the sequencer forms the
// status and, when the status is ok, while the divider runs its 32 one-bit steps
// and raises its done flag. The result register frees the input side, so bytes
// of the next file flow while a result waits; once that file's last byte is
// taken, input stays stalled until the register is empty. Reset is asynchronous,
// active low, and clears all parser state.

module wav_header_parser_core #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] format_tag_o,
  output logic [15:0] channel_count_o,
  output logic [31:0] sample_rate_o,
  output logic [12:0] bytes_per_sample_o,
  output logic [31:0] sample_count_o,
  output logic [31:0] data_offset_o
);

  wavhp_pkg::ctl_state_e ctl_q, ctl_d;
  wavhp_pkg::parse_res_t res;
  wavhp_pkg::status_e    status;

  logic        step;
  logic        clear;
  logic        div_start;
  logic        div_done;
  logic [31:0] quotient;
  logic [12:0] width;
  logic        load;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  status_q;
  logic [15:0] fmt_tag_q;
  logic [15:0] chans_q;
  logic [31:0] rate_q;
  logic [12:0] width_q;
  logic [31:0] samples_q;
  logic [31:0] offset_q;

  assign in_stall_o = (ctl_q != wavhp_pkg::CTL_PARSE);
  assign step       = in_valid_i && !in_stall_o;

  wavhp_parse #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .clear_i    (clear),
    .data_byte_i(data_byte_i),
    .res_o      (res)
  );

  wavhp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(res.data_length),
    .divisor_i (width),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  // Status from the gathered fields
  assign width = res.bits_per_sample[15:3];

  always_comb begin
    if (!res.wave_ok) begin
      status = wavhp_pkg::ST_NO_WAVE;
    end else if (!res.fmt_found) begin
      status = wavhp_pkg::ST_NO_FMT;
    end else if (res.format_tag != wavhp_pkg::FMT_PCM) begin
      status = wavhp_pkg::ST_NOT_PCM;
    end else if (!res.data_found) begin
      status = wavhp_pkg::ST_NO_DATA;
    end else if (width == '0) begin
      status = wavhp_pkg::ST_ZERO_WIDTH;
    end else begin
      status = wavhp_pkg::ST_OK;
    end
  end

  // Sequencer
  always_comb begin
    ctl_d       = ctl_q;
    load        = 1'b0;
    clear       = 1'b0;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (ctl_q)
      wavhp_pkg::CTL_PARSE: begin
        if (step && last_i) begin
          ctl_d = wavhp_pkg::CTL_FINISH;
        end
      end
      wavhp_pkg::CTL_FINISH: begin
        if (!out_valid_q) begin
          load  = 1'b1;
          clear = 1'b1;
          if (status == wavhp_pkg::ST_OK) begin
            div_start = 1'b1;
            ctl_d     = wavhp_pkg::CTL_DIV;
          end else begin
            out_valid_d = 1'b1;
            ctl_d       = wavhp_pkg::CTL_PARSE;
          end
        end
      end
      wavhp_pkg::CTL_DIV: begin
        if (div_done) begin
          out_valid_d = 1'b1;
          ctl_d       = wavhp_pkg::CTL_PARSE;
        end
      end
      default: begin
        ctl_d = wavhp_pkg::CTL_PARSE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= wavhp_pkg::CTL_PARSE;
      out_valid_q <= 1'b0;
    end else begin
      ctl_q       <= ctl_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q  <= status;
      samples_q <= '0;
      if (status == wavhp_pkg::ST_NO_WAVE || status == wavhp_pkg::ST_NO_FMT) begin
        fmt_tag_q <= '0;
        chans_q   <= '0;
        rate_q    <= '0;
        width_q   <= '0;
      end else begin
        fmt_tag_q <= res.format_tag;
        chans_q   <= res.channel_count;
        rate_q    <= res.sample_rate;
        width_q   <= width;
      end
      offset_q <= (status == wavhp_pkg::ST_OK) ? res.data_start : '0;
    end else if (ctl_q == wavhp_pkg::CTL_DIV && div_done) begin
      samples_q <= quotient;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign format_tag_o       = fmt_tag_q;
  assign channel_count_o    = chans_q;
  assign sample_rate_o      = rate_q;
  assign bytes_per_sample_o = width_q;
  assign sample_count_o     = samples_q;
  assign data_offset_o      = offset_q;

  // Checks
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ctl_q == wavhp_pkg::CTL_DIV)
    else $error("divider finished outside the divide state");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> width != '0)
    else $error("divide started with zero width");

  a_rise_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(ctl_q) == wavhp_pkg::CTL_FINISH ||
                            $past(ctl_q) == wavhp_pkg::CTL_DIV))
    else $error("result raised without a finished file");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != wavhp_pkg::ST_OK) |-> (samples_q == '0 && offset_q == '0))
    else $error("count or offset set on a failed file");

endmodule
